@@ hw/rtl/sbs_pkg.sv @@
`timescale 1ns / 1ps
// sbs_pkg: field widths, operation codes and controller state type for the
// sorted table binary search block. No dependencies.
package sbs_pkg;

  // fixed widths of the stream fields
  localparam int IDX_W      = 10;
  localparam int VAL_IN_W   = 32;
  localparam int RHI_W      = 11;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 16;

  // signed width of the low and high bounds while searching (-1024 .. 1024)
  localparam int BND_W = 12;

  // operation codes carried on s_tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_RESULT
  } state_t;

endpackage

@@ hw/rtl/sbs_table.sv @@
`timescale 1ns / 1ps
// sbs_table: single-port-write, single-port-read synchronous table memory
// with registered read data. No package dependencies.
module sbs_table #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/sorted_table_binary_search_top.sv @@
`timescale 1ns / 1ps
// Sorted table binary search: write beats store one entry, search beats run a
// binary search over the table memory. Depends on sbs_pkg and sbs_table.
// Timing: a write beat is taken in S_IDLE and gives no result. A search beat
// runs one probe after another, at most 11 for a 1024-entry range; each probe
// is a table read in S_PROBE and a compare in S_CMP, as the table memory has a
// registered read port. A hit goes from S_CMP to S_RESULT, a miss from an S_PROBE
// that finds the range empty; S_RESULT waits while the output beat is not taken.
// Throughput: one item at a time; the next beat is taken in the cycle after the
// search has handed its result to the output register. Reset (rst, synchronous,
// active high) clears the controller and the output valid; the table is not cleared.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // entry_index, entry_value, range_low, range_high, target, 1 bit zero fill
  input  logic [sbs_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // found_index, 6 bits zero fill
  output logic [sbs_pkg::OUT_DATA_W-1:0] m_tdata,
  // found
  output logic                           m_tuser
);

  import sbs_pkg::*;

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HI_LIM = (TABLE_DEPTH > 1024) ? 1023 : TABLE_DEPTH - 1;
  localparam logic signed [BND_W-1:0] HI_MAX = BND_W'(HI_LIM);

  // input field unpacking
  logic [IDX_W-1:0]           in_index;
  logic signed [VAL_IN_W-1:0] in_value;
  logic [IDX_W-1:0]           in_rlo;
  logic signed [RHI_W-1:0]    in_rhi;
  logic signed [VAL_IN_W-1:0] in_target;

  assign in_index  = s_tdata[9:0];
  assign in_value  = s_tdata[41:10];
  assign in_rlo    = s_tdata[51:42];
  assign in_rhi    = s_tdata[62:52];
  assign in_target = s_tdata[94:63];

  state_t state, state_next;

  logic signed [BND_W-1:0]       lo;
  logic signed [BND_W-1:0]       hi;
  logic [IDX_W-1:0]              mid;
  logic signed [VALUE_WIDTH-1:0] tval;
  logic                          res_found;
  logic [IDX_W-1:0]              res_idx;

  logic                          s_beat;
  logic                          out_load;
  logic                          rd_en;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic signed [VALUE_WIDTH-1:0] rd_data;

  logic signed [BND_W-1:0]       rhi_ext;
  logic signed [BND_W-1:0]       hi_start;
  logic signed [BND_W-1:0]       mid_calc;
  logic signed [BND_W-1:0]       mid_ext;
  logic                          empty;
  logic                          hit;
  logic                          go_left;
  logic [AW+IDX_W-1:0]           wr_idx_ext;
  logic [AW+IDX_W-1:0]           rd_idx_ext;

  assign s_beat = s_tvalid && s_tready;

  // write path: ignore indexes beyond the table
  assign wr_idx_ext = (AW + IDX_W)'(in_index);
  assign wr_addr    = wr_idx_ext[AW-1:0];
  assign wr_data    = VALUE_WIDTH'(in_value);
  assign wr_en      = s_beat && (s_tuser == OP_WRITE) && (32'(in_index) < 32'(TABLE_DEPTH));

  // search bounds and probe position
  assign rhi_ext    = BND_W'(in_rhi);
  assign hi_start   = (rhi_ext > HI_MAX) ? HI_MAX : rhi_ext;
  assign empty      = (lo > hi);
  assign mid_calc   = lo + ((hi - lo) >>> 1);
  assign rd_idx_ext = (AW + IDX_W)'(mid_calc[IDX_W-1:0]);
  assign rd_addr    = rd_idx_ext[AW-1:0];
  assign mid_ext    = BND_W'(mid);

  // compare of the probed entry against the target
  assign hit     = (rd_data == tval);
  assign go_left = (tval < rd_data);

  sbs_table #(
    .DEPTH  (TABLE_DEPTH),
    .WIDTH  (VALUE_WIDTH),
    .ADDR_W (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_beat && (s_tuser == OP_SEARCH)) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = empty ? S_RESULT : S_CMP;
      end
      S_CMP: begin
        state_next = hit ? S_RESULT : S_PROBE;
      end
      S_RESULT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE:   s_tready = 1'b1;
      S_PROBE:  rd_en    = !empty;
      S_CMP:    ;
      S_RESULT: out_load = !m_tvalid || m_tready;
      default:  ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        lo        <= BND_W'(in_rlo);
        hi        <= hi_start;
        tval      <= VALUE_WIDTH'(in_target);
        res_found <= 1'b0;
        res_idx   <= '0;
      end
      S_PROBE: begin
        mid <= mid_calc[IDX_W-1:0];
      end
      S_CMP: begin
        if (hit) begin
          res_found <= 1'b1;
          res_idx   <= mid;
        end else if (go_left) begin
          hi <= mid_ext - BND_W'(1);
        end else begin
          lo <= mid_ext + BND_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_DATA_W'(res_idx);
      m_tuser <= res_found;
    end
  end

  // checks
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (s_beat && (s_tuser == OP_SEARCH)) |=> (state == S_PROBE))
    else $error("search beat did not start a probe");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((mid_ext >= lo) && (mid_ext <= hi)))
    else $error("probe position outside the search bounds");

  a_read_then_cmp: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == S_CMP))
    else $error("table read not followed by compare");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found result with nonzero index");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !wr_en)
    else $error("table write during a search");

endmodule

@@ verif/sbs_search_checker.sv @@
`timescale 1ns / 1ps
// sbs_search_checker: watches both stream channels of the sorted table binary
// search block, keeps its own copy of the table and predicts each search result.
// Depends on sbs_pkg for field widths and operation codes.
module sbs_search_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [sbs_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [sbs_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tuser,
  output int                             mismatch_count,
  output int                             pending_count
);
  import sbs_pkg::*;

  localparam int DEPTH     = 1024;
  // bit positions of the fields in s_tdata
  localparam int ENTRY_LSB = 0;
  localparam int VALUE_LSB = 10;
  localparam int RLO_LSB   = 42;
  localparam int RHI_LSB   = 52;
  localparam int TGT_LSB   = 63;

  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     where;
  } hit_t;

  logic signed [VAL_IN_W-1:0] value_mem [DEPTH];
  hit_t                       hit_q [$];

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    for (int i = 0; i < DEPTH; i++) value_mem[i] = '0;
  end

  // binary search over the local table copy
  function automatic hit_t bsearch_predict(input logic [IDX_W-1:0] rlo,
                                           input logic [RHI_W-1:0] rhi,
                                           input logic signed [VAL_IN_W-1:0] tgt);
    int   lo;
    int   hi;
    int   mid;
    hit_t r;
    lo = int'(rlo);
    hi = int'($signed(rhi));
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    r = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (value_mem[mid] == tgt) begin
        r.found = 1'b1;
        r.where = mid[IDX_W-1:0];
        break;
      end else if (tgt < value_mem[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    hit_t want;
    if (rst) begin
      hit_q.delete();
    end else begin
      // result beat against the oldest pending search
      if (m_tvalid && m_tready) begin
        if (hit_q.size() == 0) begin
          $display("%0t unexpected result beat: found=%0d index=%0d",
                   $time, m_tuser, m_tdata[IDX_W-1:0]);
          mismatch_count++;
        end else begin
          want = hit_q.pop_front();
          if (m_tuser !== want.found) begin
            $display("%0t found mismatch: expected %0d, actual %0d",
                     $time, want.found, m_tuser);
            mismatch_count++;
          end
          if (m_tdata[IDX_W-1:0] !== want.where) begin
            $display("%0t found_index mismatch: expected %0d, actual %0d",
                     $time, want.where, m_tdata[IDX_W-1:0]);
            mismatch_count++;
          end
        end
      end
      // input beat: write updates the table, search queues a prediction
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_WRITE) begin
          value_mem[s_tdata[ENTRY_LSB +: IDX_W]] = s_tdata[VALUE_LSB +: VAL_IN_W];
        end else begin
          hit_q.push_back(bsearch_predict(s_tdata[RLO_LSB +: IDX_W],
                                          s_tdata[RHI_LSB +: RHI_W],
                                          s_tdata[TGT_LSB +: VAL_IN_W]));
        end
      end
    end
    pending_count = hit_q.size();
  end

endmodule

@@ verif/tb_sorted_table_binary_search_top.sv @@
`timescale 1ns / 1ps
// tb_sorted_table_binary_search_top: drives write and search beats into the
// sorted table binary search block and gives the verdict.
// Depends on sbs_pkg, sorted_table_binary_search_top and sbs_search_checker.
module tb_sorted_table_binary_search_top;
  import sbs_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int BEAT_TARGET  = 426;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int                    mismatch_count;
  int                    pending_count;
  int                    beats_sent = 0;
  int                    idle_odds = 0;
  int                    stall_left = 0;
  int                    cycle_count = 0;
  logic signed [31:0]    shadow [DEPTH];

  sorted_table_binary_search_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sbs_search_checker chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      stall_left <= $urandom_range(0, 5);
      m_tready   <= 1'b0;
    end else begin
      m_tready   <= 1'b1;
    end
  end

  // fields from the lowest bit up, top bit zero
  function automatic logic [IN_DATA_W-1:0] pack_beat(input logic [9:0] idx,
                                                     input logic [31:0] val,
                                                     input logic [9:0] rlo,
                                                     input logic [10:0] rhi,
                                                     input logic [31:0] tgt);
    return {1'b0, tgt, rhi, rlo, val, idx};
  endfunction

  // one beat, with an optional gap in front of it
  task automatic send_beat(input logic op, input logic [IN_DATA_W-1:0] data);
    if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // search fields carry noise on a write
  task automatic write_entry(input int idx, input logic [31:0] val);
    shadow[idx] = val;
    send_beat(OP_WRITE, pack_beat(idx[9:0], val, 10'($urandom_range(0, 1023)),
                                  11'($urandom_range(0, 2047)), $urandom));
  endtask

  // write fields carry noise on a search
  task automatic search_range(input int lo, input int hi, input logic [31:0] tgt);
    logic [10:0] rhi;
    rhi = hi[10:0];
    send_beat(OP_SEARCH, pack_beat(10'($urandom_range(0, 1023)), $urandom, lo[9:0],
                                   rhi, tgt));
  endtask

  initial begin
    int       base;
    int       n;
    int       run_end;
    int       lo;
    int       hi;
    int       tidx;
    int       nsearch;
    int       pick;
    int       tmp;
    longint   cur;
    int       step_max;
    bit       sorted_run;
    logic [31:0] tgt;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= OP_WRITE;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: a short sorted table spanning the signed extremes
    write_entry(0, 32'h8000_0000);
    write_entry(1, -1000);
    write_entry(2, -1);
    write_entry(3, 0);
    write_entry(4, 1);
    write_entry(5, 5000);
    write_entry(6, 32'h7FFF_FFFE);
    write_entry(7, 32'h7FFF_FFFF);
    write_entry(1022, 40);
    write_entry(1023, 42);
    search_range(0, 7, 32'h8000_0000);
    search_range(0, 7, 32'h7FFF_FFFF);
    search_range(0, 7, 0);
    search_range(0, 7, -2);
    search_range(0, 7, 2);
    search_range(1, 7, 32'h8000_0000);
    search_range(0, 6, 32'h7FFF_FFFF);
    // empty ranges: high of -1 and high below low; then single-entry and top-end ranges
    search_range(0, -1, 0);
    search_range(5, 3, 5000);
    search_range(4, 4, 1);
    search_range(1023, 1023, 42);
    search_range(1022, 1023, 41);
    // unsorted table: same probe order, result may be a miss
    write_entry(3, -5);
    search_range(0, 7, -5);
    search_range(0, 7, -1);
    write_entry(3, 0);

    // random rounds: fill a run, then search inside it
    while (beats_sent < BEAT_TARGET) begin
      if (beats_sent > BEAT_TARGET * 85 / 100) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 10;
          2: idle_odds = 30;
          default: idle_odds = 60;
        endcase
      end
      base = $urandom_range(0, DEPTH - 1);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 300);
      else n = $urandom_range(1, 32);
      if (n > DEPTH - base) n = DEPTH - base;
      run_end    = base + n - 1;
      sorted_run = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 2))
        0: cur = -64'sd2147483648;
        1: begin
          tmp = $urandom;
          cur = tmp;
        end
        default: cur = $urandom_range(0, 100) - 50;
      endcase
      case ($urandom_range(0, 2))
        0: step_max = 3;
        1: step_max = 1000;
        default: step_max = 1 << 24;
      endcase
      for (int i = base; i <= run_end; i++) begin
        if (sorted_run) begin
          write_entry(i, cur[31:0]);
          cur = cur + $urandom_range(0, step_max);
          if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        end else begin
          write_entry(i, $urandom);
        end
      end
      // stray write anywhere, may break the order of the run
      if ($urandom_range(0, 5) == 0) write_entry($urandom_range(0, DEPTH - 1), $urandom);

      nsearch = $urandom_range(1, 4 + n / 16);
      for (int k = 0; k < nsearch; k++) begin
        lo = $urandom_range(base, run_end);
        hi = $urandom_range(lo, run_end);
        if ($urandom_range(0, 4) == 0) begin
          lo = base;
          hi = run_end;
        end
        tidx = $urandom_range(lo, hi);
        pick = $urandom_range(0, 9);
        if (pick < 5) tgt = shadow[tidx];
        else if (pick < 7) tgt = $urandom_range(0, 1) ? shadow[tidx] + 1 : shadow[tidx] - 1;
        else tgt = $urandom;
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) hi = -1;
          else hi = lo - 1;
        end
        search_range(lo, hi, tgt);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
